// ----- sv/scu_pkg.sv -----
// Shared types, codes and constants for the single-use cookie table.
package scu_pkg;

    localparam logic [1:0] MODE_CREATE     = 2'd0;
    localparam logic [1:0] MODE_CONSUME    = 2'd1;
    localparam logic [1:0] MODE_INVALIDATE = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_REPLAY   = 3'd4;
    localparam logic [2:0] ST_EXPIRED  = 3'd5;
    localparam logic [2:0] ST_NOTFOUND = 3'd6;

    localparam logic [63:0] SALT_RESET = 64'h0000_0000_20E6_F8F7;
    localparam logic [31:0] XS_MULT_LO = 32'h4F6C_DD1D;
    localparam logic [31:0] XS_MULT_HI = 32'h2545_F491;
    localparam int          ROT_SEED   = 17;

    typedef struct packed {
        logic       load_in;
        logic       set_status;
        logic [2:0] status;
        logic       scan_start;
        logic       scan_run;
        logic       scan_free;
        logic       seed;
        logic       xs;
        logic       mul0;
        logic       mul1;
        logic       mul2;
        logic       half;
        logic       commit;
        logic       resolve;
        logic       out_load;
    } scu_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       create_ok;
        logic       null_ticket;
        logic       scan_hit;
        logic       scan_miss;
    } scu_stat_t;

    function automatic logic [63:0] xorshift64(input logic [63:0] s);
        logic [63:0] x;
        x = s;
        x = x ^ (x >> 12);
        x = x ^ (x << 25);
        x = x ^ (x >> 27);
        return x;
    endfunction

endpackage

// ----- sv/scu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module scu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                  wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/scu_ctrl.sv -----
// Sequencer for create, consume and invalidate requests.
module scu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  scu_pkg::scu_stat_t stat,
    output scu_pkg::scu_cmd_t  cmd
);
    import scu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SCAN, S_SEED, S_XS, S_MUL0, S_MUL1, S_MUL2,
        S_WRITE, S_RESOLVE, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   half_reg, half_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.half       = half_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                case (stat.mode)
                    MODE_CREATE:
                    begin
                        if (stat.create_ok)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        else
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_INVALID;
                            state_next     = S_FINISH;
                        end
                    end
                    MODE_CONSUME, MODE_INVALIDATE:
                    begin
                        if (stat.null_ticket)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = (stat.mode == MODE_CONSUME) ? ST_INVALID : ST_OK;
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_INVALID;
                        state_next     = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_run  = 1'b1;
                cmd.scan_free = (stat.mode == MODE_CREATE);
                if (stat.scan_hit)
                begin
                    half_next  = 1'b0;
                    state_next = (stat.mode == MODE_CREATE) ? S_SEED : S_RESOLVE;
                end
                else if (stat.scan_miss)
                begin
                    cmd.set_status = 1'b1;
                    case (stat.mode)
                        MODE_CREATE:  cmd.status = ST_FULL;
                        MODE_CONSUME: cmd.status = ST_NOTFOUND;
                        default:      cmd.status = ST_OK;
                    endcase
                    state_next = S_FINISH;
                end
            end
            S_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = S_XS;
            end
            S_XS:
            begin
                cmd.xs     = 1'b1;
                state_next = S_MUL0;
            end
            S_MUL0:
            begin
                cmd.mul0   = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2 = 1'b1;
                if (half_reg)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    half_next  = 1'b1;
                    state_next = S_XS;
                end
            end
            S_WRITE:
            begin
                cmd.commit = 1'b1;
                state_next = S_FINISH;
            end
            S_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ----- sv/scu_dp.sv -----
// Datapath: request registers, slot scan, ticket generator, entry store, result.
module scu_dp #(
    parameter int TABLE_SLOTS = 64,
    parameter int CLUSTER_MAX = 16,
    parameter int PAGE_SHIFT  = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  scu_pkg::scu_cmd_t  cmd,
    output scu_pkg::scu_stat_t stat,
    input  logic               cfg_wr_en,
    input  logic [63:0]        cfg_wr_data,
    input  logic [1:0]         mode,
    input  logic [63:0]        ticket_lo,
    input  logic [63:0]        ticket_hi,
    input  logic [63:0]        cluster_base,
    input  logic [10:0]        page_count,
    input  logic [7:0]         access_bits,
    input  logic [63:0]        expiry_time,
    input  logic [63:0]        now_time,
    output logic [2:0]         status,
    output logic [63:0]        minted_lo,
    output logic [63:0]        minted_hi,
    output logic [7:0]         granted_access,
    output logic [63:0]        granted_expiry,
    output logic [6:0]         live_entries
);
    import scu_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS > 1 ? TABLE_SLOTS : 2);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int PG_W  = $clog2(CLUSTER_MAX + 1);
    localparam int RAM_W = 64 * 4 + PG_W + 8;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    logic [1:0]  mode_reg;
    logic [63:0] tlo_reg, thi_reg, base_reg, expiry_reg, now_reg;
    logic [10:0] pages_reg;
    logic [7:0]  access_reg;

    logic [TABLE_SLOTS-1:0] live_reg, used_reg;
    logic [CNT_W-1:0]       count_reg;

    logic [IDX_W-1:0] scan_idx_reg, cmp_idx_reg, hit_idx_reg;
    logic             issue_reg, cmp_vld_reg, cmp_last_reg;

    logic [63:0] gen_reg, acc_reg;
    logic        seeded_reg;

    logic [63:0]     ent_base_reg, ent_deadline_reg;
    logic [PG_W-1:0] ent_pages_reg;
    logic [7:0]      ent_access_reg;

    logic [2:0]  res_status_reg;
    logic [63:0] res_mlo_reg, res_mhi_reg, res_gexp_reg;
    logic [7:0]  res_gacc_reg;

    logic [2:0]  out_status_reg;
    logic [63:0] out_mlo_reg, out_mhi_reg, out_gexp_reg;
    logic [7:0]  out_gacc_reg;
    logic [6:0]  out_live_reg;

    logic [RAM_W-1:0] wdata, rdata;
    logic [63:0]      rd_tlo, rd_thi, rd_base, rd_deadline;
    logic [PG_W-1:0]  rd_pages;
    logic [7:0]       rd_access;
    logic             hit, match;
    logic [31:0]      p_cross0, p_cross1;
    logic [63:0]      p_low, mint_sum, mint;
    logic             expired;

    assign wdata = {res_mlo_reg, res_mhi_reg, base_reg, PG_W'(pages_reg), access_reg, expiry_reg};
    assign {rd_tlo, rd_thi, rd_base, rd_pages, rd_access, rd_deadline} = rdata;

    scu_ram #(.WIDTH(RAM_W), .DEPTH(TABLE_SLOTS)) u_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (hit_idx_reg),
        .wdata (wdata),
        .raddr (scan_idx_reg),
        .rdata (rdata)
    );

    assign match = live_reg[cmp_idx_reg] && rd_tlo == tlo_reg && rd_thi == thi_reg;
    assign hit   = cmd.scan_run && cmp_vld_reg &&
                   (cmd.scan_free ? !live_reg[cmp_idx_reg] : match);

    assign stat.mode        = mode_reg;
    assign stat.create_ok   = pages_reg != 11'd0 && pages_reg <= 11'(CLUSTER_MAX) &&
                              base_reg[PAGE_SHIFT-1:0] == '0 && access_reg[2:0] != 3'd0;
    assign stat.null_ticket = tlo_reg == 64'd0 && thi_reg == 64'd0;
    assign stat.scan_hit    = hit;
    assign stat.scan_miss   = cmd.scan_run && cmp_vld_reg && cmp_last_reg && !hit;

    assign p_low    = {32'd0, gen_reg[31:0]} * {32'd0, XS_MULT_LO};
    assign p_cross0 = gen_reg[31:0] * XS_MULT_HI;
    assign p_cross1 = gen_reg[63:32] * XS_MULT_LO;
    assign mint_sum = acc_reg + {p_cross1, 32'd0};
    assign mint     = (mint_sum == 64'd0) ? 64'd1 : mint_sum;

    assign expired = ent_deadline_reg != 64'd0 && now_reg != 64'd0 && now_reg > ent_deadline_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg   <= mode;
            tlo_reg    <= ticket_lo;
            thi_reg    <= ticket_hi;
            base_reg   <= cluster_base;
            pages_reg  <= page_count;
            access_reg <= access_bits;
            expiry_reg <= expiry_time;
            now_reg    <= now_time;
        end
        if (hit)
        begin
            hit_idx_reg      <= cmp_idx_reg;
            ent_base_reg     <= rd_base;
            ent_pages_reg    <= rd_pages;
            ent_access_reg   <= rd_access;
            ent_deadline_reg <= rd_deadline;
        end
        if (cmd.mul0)
        begin
            acc_reg <= p_low;
        end
        if (cmd.mul1)
        begin
            acc_reg <= acc_reg + {p_cross0, 32'd0};
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_mlo_reg    <= res_mlo_reg;
            out_mhi_reg    <= res_mhi_reg;
            out_gacc_reg   <= res_gacc_reg;
            out_gexp_reg   <= res_gexp_reg;
            out_live_reg   <= 7'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg     <= '0;
            used_reg     <= '0;
            count_reg    <= '0;
            gen_reg      <= SALT_RESET;
            seeded_reg   <= 1'b0;
            scan_idx_reg <= '0;
            cmp_idx_reg  <= '0;
            issue_reg    <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            cmp_last_reg <= 1'b0;
            res_status_reg <= ST_OK;
            res_mlo_reg  <= '0;
            res_mhi_reg  <= '0;
            res_gacc_reg <= '0;
            res_gexp_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                gen_reg    <= cfg_wr_data;
                seeded_reg <= 1'b0;
            end
            if (cmd.load_in)
            begin
                res_status_reg <= ST_OK;
                res_mlo_reg    <= '0;
                res_mhi_reg    <= '0;
                res_gacc_reg   <= '0;
                res_gexp_reg   <= '0;
            end
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status;
            end
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                issue_reg    <= 1'b1;
                cmp_vld_reg  <= 1'b0;
                cmp_last_reg <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                cmp_vld_reg  <= issue_reg;
                cmp_idx_reg  <= scan_idx_reg;
                cmp_last_reg <= scan_idx_reg == LAST_IDX;
                if (issue_reg)
                begin
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
            end
            if (cmd.seed && !seeded_reg)
            begin
                if (now_reg != 64'd0)
                begin
                    gen_reg <= gen_reg ^ now_reg ^
                               {now_reg[63-ROT_SEED:0], now_reg[63:64-ROT_SEED]};
                end
                seeded_reg <= 1'b1;
            end
            if (cmd.xs)
            begin
                gen_reg <= xorshift64(gen_reg);
            end
            if (cmd.mul2)
            begin
                if (cmd.half)
                begin
                    res_mhi_reg <= mint;
                end
                else
                begin
                    res_mlo_reg <= mint;
                end
            end
            if (cmd.commit)
            begin
                live_reg[hit_idx_reg] <= 1'b1;
                used_reg[hit_idx_reg] <= 1'b0;
                count_reg             <= count_reg + 1'b1;
                res_status_reg        <= ST_OK;
            end
            if (cmd.resolve)
            begin
                if (mode_reg == MODE_CONSUME)
                begin
                    if (ent_base_reg != base_reg || 11'(ent_pages_reg) != pages_reg)
                    begin
                        res_status_reg <= ST_MISMATCH;
                    end
                    else if (used_reg[hit_idx_reg])
                    begin
                        res_status_reg <= ST_REPLAY;
                    end
                    else if (expired)
                    begin
                        live_reg[hit_idx_reg] <= 1'b0;
                        used_reg[hit_idx_reg] <= 1'b0;
                        count_reg             <= count_reg - 1'b1;
                        res_status_reg        <= ST_EXPIRED;
                    end
                    else
                    begin
                        live_reg[hit_idx_reg] <= 1'b0;
                        used_reg[hit_idx_reg] <= 1'b1;
                        count_reg             <= count_reg - 1'b1;
                        res_gacc_reg          <= ent_access_reg;
                        res_gexp_reg          <= ent_deadline_reg;
                        res_status_reg        <= ST_OK;
                    end
                end
                else
                begin
                    live_reg[hit_idx_reg] <= 1'b0;
                    used_reg[hit_idx_reg] <= 1'b0;
                    count_reg             <= count_reg - 1'b1;
                    res_status_reg        <= ST_OK;
                end
            end
        end
    end

    assign status         = out_status_reg;
    assign minted_lo      = out_mlo_reg;
    assign minted_hi      = out_mhi_reg;
    assign granted_access = out_gacc_reg;
    assign granted_expiry = out_gexp_reg;
    assign live_entries   = out_live_reg;
endmodule

// ----- sv/single_use_cookie_table.sv -----
// Top level: single-use cookie table, controller plus datapath.
// Create finds the first free slot, mints both ticket halves, then writes the entry;
// consume and invalidate find the matching slot and resolve it; misses scan all slots.
// Rejected requests end after the check. One request is in flight at a time, paced
// by the sequential slot scan over the entry RAM and the three-step 64-bit multiply.
// Reset (rst_n, async low) clears all slots, the live count and the seeded flag, and
// loads the generator with the seed salt reset value; entry RAM is not cleared.
module single_use_cookie_table #(
    parameter int TABLE_SLOTS = 64,
    parameter int CLUSTER_MAX = 16,
    parameter int PAGE_SHIFT  = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [63:0] ticket_lo,
    input  logic [63:0] ticket_hi,
    input  logic [63:0] cluster_base,
    input  logic [10:0] page_count,
    input  logic [7:0]  access_bits,
    input  logic [63:0] expiry_time,
    input  logic [63:0] now_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [63:0] minted_lo,
    output logic [63:0] minted_hi,
    output logic [7:0]  granted_access,
    output logic [63:0] granted_expiry,
    output logic [6:0]  live_entries
);
    import scu_pkg::*;

    scu_cmd_t  cmd;
    scu_stat_t stat;

    scu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    scu_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .CLUSTER_MAX (CLUSTER_MAX),
        .PAGE_SHIFT  (PAGE_SHIFT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mode           (mode),
        .ticket_lo      (ticket_lo),
        .ticket_hi      (ticket_hi),
        .cluster_base   (cluster_base),
        .page_count     (page_count),
        .access_bits    (access_bits),
        .expiry_time    (expiry_time),
        .now_time       (now_time),
        .status         (status),
        .minted_lo      (minted_lo),
        .minted_hi      (minted_hi),
        .granted_access (granted_access),
        .granted_expiry (granted_expiry),
        .live_entries   (live_entries)
    );
endmodule

// ----- sv/scu_checker.sv -----
// Port-level checks for the single-use cookie table, bound to the top level.
module scu_checker #(
    parameter int TABLE_SLOTS = 64
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [63:0] minted_lo,
    input logic [63:0] minted_hi,
    input logic [7:0]  granted_access,
    input logic [6:0]  live_entries
);
    import scu_pkg::*;

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(minted_lo))
        else $error("result beat changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 3'd7)
        else $error("undefined status code");

    // minted halves are never zero, so both or neither are present
    a_mint_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && minted_lo == 64'd0 |-> minted_hi == 64'd0)
        else $error("half of a ticket minted");

    a_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && granted_access != 8'd0 |-> status == ST_OK && minted_lo == 64'd0)
        else $error("access granted on a failed or create beat");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && TABLE_SLOTS < 128 |-> 32'(live_entries) <= TABLE_SLOTS)
        else $error("live count above table size");
endmodule

bind single_use_cookie_table scu_checker #(.TABLE_SLOTS(TABLE_SLOTS)) u_scu_checker (.*);
